// ===== design/ssrc_pkg.sv =====
// Shared types and constants for the shadow return-address stack checker.
package ssrc_pkg;

  localparam int STATUS_W = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_FILTERED  = 4'd0,
    STATUS_PUSHED    = 4'd1,
    STATUS_UNKNOWN   = 4'd2,
    STATUS_READ_ERR  = 4'd3,
    STATUS_MATCH     = 4'd4,
    STATUS_VIOLATION = 4'd5,
    STATUS_EMPTY     = 4'd6,
    STATUS_FOLLOW    = 4'd7,
    STATUS_FULL      = 4'd8
  } status_e;

  localparam logic KIND_CALL = 1'b0;
  localparam logic KIND_RETURN = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_ENABLE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WATCHED_THREAD = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FIXUP_ENABLE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REC,
    S_STORE
  } state_e;

  // Facts about one event once both memory reads have returned.
  typedef struct packed {
    logic active;
    logic kind;
    logic read_ok;
    logic target_known;
    logic ret_immediate;
    logic empty;
    logic full;
    logic match;
    logic fixup;
  } eval_in_t;

  // Decision for one event.
  typedef struct packed {
    status_e status;
    logic    push;
    logic    pop;
    logic    count_viol;
    logic    count_nonroot;
    logic    repair;
    logic    show_expected;
    logic    show_found;
  } eval_ctl_t;

endpackage

// ===== design/shadow_stack_return_checker_unit.sv =====
// Shadow return-address stack checker: top level.
//
// Events enter on the input channel (in_valid/in_stall); one result beat per
// event leaves on the output channel (out_valid/out_stall). Configuration
// registers are written over cfg_valid/cfg_ready/cfg_index/cfg_data; the user
// must write them only while idle (unenforced); cfg_ready is always high.
//
// For each event the per-thread record memory (depth and counters) is read
// first, its depth then addresses the return-address memory, and in S_STORE
// the outcome is written back and loaded into the output register. One event
// is in work at a time, so a new event is not accepted until the last one
// has left S_STORE.
//
// The output register lets the next event be accepted while a result waits.
// If the receiver stalls, the following event finishes its reads and then
// holds, with no state written, until the output register is free.
//
// Reset clears the per-thread valid bits (a record not yet written reads as
// zero depth and zero counts), the global counters and the configuration.
// The return-address memory is not cleared: only entries below a depth are
// read. No clearing pass is needed; the block is ready right after reset.
module shadow_stack_return_checker_unit #(
  parameter int THREADS = 8,
  parameter int STACK_DEPTH = 64,
  parameter int COUNT_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ssrc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ssrc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic [2:0]                        thread,
  input  logic [63:0]                       stack_word,
  input  logic                              read_ok,
  input  logic                              target_known,
  input  logic                              ret_immediate,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ssrc_pkg::STATUS_W-1:0]     status,
  output logic [63:0]                       expected_address,
  output logic [63:0]                       found_address,
  output logic                              repair,
  output logic [6:0]                        depth,
  output logic [31:0]                       violations_total,
  output logic [31:0]                       nonroot_total,
  output logic [31:0]                       thread_violation_count,
  output logic [31:0]                       thread_nonroot_count
);

  localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int SW = $clog2(THREADS * STACK_DEPTH);
  localparam int RW = DW + 2 * COUNT_BITS;

  ssrc_pkg::state_e state, state_next;

  logic filter_enable;
  logic [2:0] watched_thread;
  logic fixup_enable;

  logic in_accept;
  logic finish;
  logic valid_tid;

  logic kind_q;
  logic [2:0] tid_q;
  logic [63:0] word_q;
  logic read_ok_q;
  logic known_q;
  logic retimm_q;
  logic active_q;
  logic tid_ok_q;
  logic rec_hit_q;

  logic [THREADS-1:0] rec_valid;
  logic [RW-1:0] rec_rdata;
  logic [RW-1:0] rec_wdata;
  logic rec_we;

  logic [63:0] st_rdata;
  logic [SW-1:0] st_addr;
  logic [SW-1:0] st_addr_q;
  logic [DW-1:0] slot;

  logic [DW-1:0] d_cur, d_new;
  logic [COUNT_BITS-1:0] v_cur, v_new, n_cur, n_new;
  logic [COUNT_BITS-1:0] gv, gv_next, gn, gn_next;

  ssrc_pkg::eval_in_t ev;
  ssrc_pkg::eval_ctl_t ctl;

  assign cfg_ready = 1'b1;
  assign valid_tid = 32'(thread) < THREADS;
  assign in_stall = (state != ssrc_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign finish = (state == ssrc_pkg::S_STORE) && (!out_valid || !out_stall);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b0;
      watched_thread <= '0;
      fixup_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ssrc_pkg::REG_FILTER_ENABLE:  filter_enable <= cfg_data[0];
        ssrc_pkg::REG_WATCHED_THREAD: watched_thread <= cfg_data[2:0];
        ssrc_pkg::REG_FIXUP_ENABLE:   fixup_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Event capture.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_q <= kind;
      tid_q <= thread;
      word_q <= stack_word;
      read_ok_q <= read_ok;
      known_q <= target_known;
      retimm_q <= ret_immediate;
      tid_ok_q <= valid_tid;
      active_q <= valid_tid && !(filter_enable && (thread != watched_thread));
      rec_hit_q <= valid_tid && rec_valid[TW'(thread)];
    end
  end

  // Per-thread record: depth, violation count, non-root count.
  ssrc_ram #(
    .WIDTH(RW),
    .DEPTH(THREADS)
  ) u_rec_ram (
    .clk    (clk),
    .wr_en  (rec_we),
    .wr_addr(TW'(tid_q)),
    .wr_data(rec_wdata),
    .rd_en  (in_accept),
    .rd_addr(TW'(thread)),
    .rd_data(rec_rdata)
  );

  always_comb begin
    if (rec_hit_q) begin
      d_cur = rec_rdata[DW-1:0];
      v_cur = rec_rdata[DW +: COUNT_BITS];
      n_cur = rec_rdata[DW+COUNT_BITS +: COUNT_BITS];
    end else begin
      d_cur = '0;
      v_cur = '0;
      n_cur = '0;
    end
  end

  // A call addresses the free slot, a return the top entry.
  assign slot = (kind_q == ssrc_pkg::KIND_CALL) ? d_cur : d_cur - 1'b1;
  assign st_addr = SW'(tid_q) * SW'(STACK_DEPTH) + SW'(slot);

  always_ff @(posedge clk) begin
    if (state == ssrc_pkg::S_REC) begin
      st_addr_q <= st_addr;
    end
  end

  ssrc_ram #(
    .WIDTH(64),
    .DEPTH(THREADS * STACK_DEPTH)
  ) u_store_ram (
    .clk    (clk),
    .wr_en  (finish && ctl.push),
    .wr_addr(st_addr_q),
    .wr_data(word_q),
    .rd_en  (state == ssrc_pkg::S_REC),
    .rd_addr(st_addr),
    .rd_data(st_rdata)
  );

  always_comb begin
    ev.active = active_q;
    ev.kind = kind_q;
    ev.read_ok = read_ok_q;
    ev.target_known = known_q;
    ev.ret_immediate = retimm_q;
    ev.empty = (d_cur == '0);
    ev.full = (d_cur >= DW'(STACK_DEPTH));
    ev.match = (word_q == st_rdata);
    ev.fixup = fixup_enable;
  end

  ssrc_eval u_eval (
    .ev (ev),
    .ctl(ctl)
  );

  always_comb begin
    d_new = d_cur;
    if (ctl.push) begin
      d_new = d_cur + 1'b1;
    end else if (ctl.pop) begin
      d_new = d_cur - 1'b1;
    end
    v_new = v_cur;
    gv_next = gv;
    if (ctl.count_viol) begin
      v_new = (v_cur == {COUNT_BITS{1'b1}}) ? v_cur : v_cur + 1'b1;
      gv_next = (gv == {COUNT_BITS{1'b1}}) ? gv : gv + 1'b1;
    end
    n_new = n_cur;
    gn_next = gn;
    if (ctl.count_nonroot) begin
      n_new = (n_cur == {COUNT_BITS{1'b1}}) ? n_cur : n_cur + 1'b1;
      gn_next = (gn == {COUNT_BITS{1'b1}}) ? gn : gn + 1'b1;
    end
  end

  assign rec_we = finish && (ctl.push || ctl.pop || ctl.count_viol || ctl.count_nonroot);
  assign rec_wdata = {n_new, v_new, d_new};

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= '0;
      gv <= '0;
      gn <= '0;
    end else if (finish) begin
      gv <= gv_next;
      gn <= gn_next;
      if (rec_we) begin
        rec_valid[TW'(tid_q)] <= 1'b1;
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssrc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ssrc_pkg::S_IDLE: begin
        if (in_accept) begin
          state_next = ssrc_pkg::S_REC;
        end
      end
      ssrc_pkg::S_REC: begin
        state_next = ssrc_pkg::S_STORE;
      end
      ssrc_pkg::S_STORE: begin
        if (finish) begin
          state_next = ssrc_pkg::S_IDLE;
        end
      end
      default: state_next = ssrc_pkg::S_IDLE;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status <= ctl.status;
      expected_address <= ctl.show_expected ? st_rdata : 64'd0;
      found_address <= ctl.show_found ? word_q : 64'd0;
      repair <= ctl.repair;
      depth <= tid_ok_q ? 7'(d_new) : 7'd0;
      violations_total <= 32'(gv_next);
      nonroot_total <= 32'(gn_next);
      thread_violation_count <= tid_ok_q ? 32'(v_new) : 32'd0;
      thread_nonroot_count <= tid_ok_q ? 32'(n_new) : 32'd0;
    end
  end

endmodule

// ===== design/ssrc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ssrc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/ssrc_eval.sv =====
// Outcome decision for one call or return event.
module ssrc_eval (
  input  ssrc_pkg::eval_in_t  ev,
  output ssrc_pkg::eval_ctl_t ctl
);

  always_comb begin
    ctl = '0;
    ctl.status = ssrc_pkg::STATUS_FILTERED;
    if (ev.active) begin
      if (ev.kind == ssrc_pkg::KIND_CALL) begin
        if (!ev.read_ok) begin
          ctl.status = ssrc_pkg::STATUS_READ_ERR;
        end else if (!ev.target_known) begin
          ctl.status = ssrc_pkg::STATUS_UNKNOWN;
        end else if (ev.full) begin
          ctl.status = ssrc_pkg::STATUS_FULL;
        end else begin
          ctl.status = ssrc_pkg::STATUS_PUSHED;
          ctl.push = 1'b1;
        end
      end else if (ev.empty) begin
        ctl.status = ssrc_pkg::STATUS_EMPTY;
        ctl.count_nonroot = 1'b1;
      end else begin
        ctl.show_expected = 1'b1;
        if (!ev.read_ok) begin
          ctl.status = ssrc_pkg::STATUS_READ_ERR;
          ctl.pop = 1'b1;
        end else begin
          ctl.show_found = 1'b1;
          if (ev.match) begin
            ctl.status = ssrc_pkg::STATUS_MATCH;
            ctl.pop = 1'b1;
          end else if (ev.ret_immediate) begin
            // Exempt site: the transfer is allowed and the entry stays.
            ctl.status = ssrc_pkg::STATUS_FOLLOW;
          end else begin
            ctl.status = ssrc_pkg::STATUS_VIOLATION;
            ctl.pop = 1'b1;
            ctl.count_viol = 1'b1;
            ctl.repair = ev.fixup;
          end
        end
      end
    end
  end

endmodule

// ===== design/ssrc_checker.sv =====
// Port-level checks for the shadow return-address stack checker.
module ssrc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [ssrc_pkg::STATUS_W-1:0] status,
  input logic [63:0]                   expected_address,
  input logic [63:0]                   found_address,
  input logic                          repair
);

  // A result beat held by the receiver keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(expected_address)
      && $stable(found_address) && $stable(repair))
    else $error("stalled result beat changed");

  // A repair is only ever requested for a violation.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && repair |-> status == ssrc_pkg::STATUS_VIOLATION)
    else $error("repair without violation");

  // A match means the saved and seen addresses agree.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ssrc_pkg::STATUS_MATCH |-> expected_address == found_address)
    else $error("match with differing addresses");

  // Filtered events and empty-stack returns carry no addresses.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ssrc_pkg::STATUS_FILTERED || status == ssrc_pkg::STATUS_EMPTY)
      |-> expected_address == 64'd0 && found_address == 64'd0 && !repair)
    else $error("addresses reported without a comparison");

endmodule

bind shadow_stack_return_checker_unit ssrc_checker u_ssrc_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the shadow return-address stack checker.
module testbench;

  localparam int THREAD_COUNT = 8;
  localparam int STACK_LIMIT = 64;
  localparam int IDLE_PCT = 23;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic        kind;
    logic [2:0]  thread;
    logic [63:0] word;
    logic        read_ok;
    logic        target_known;
    logic        ret_immediate;
  } event_t;

  typedef struct packed {
    ssrc_pkg::status_e status;
    logic [63:0] expected_address;
    logic [63:0] found_address;
    logic        repair;
    logic [6:0]  depth;
    logic [31:0] violations_total;
    logic [31:0] nonroot_total;
    logic [31:0] thread_violation_count;
    logic [31:0] thread_nonroot_count;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ssrc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ssrc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = 1'b0;
  logic [2:0] thread = '0;
  logic [63:0] stack_word = '0;
  logic read_ok = 1'b0;
  logic target_known = 1'b0;
  logic ret_immediate = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ssrc_pkg::STATUS_W-1:0] status;
  logic [63:0] expected_address;
  logic [63:0] found_address;
  logic repair;
  logic [6:0] depth;
  logic [31:0] violations_total;
  logic [31:0] nonroot_total;
  logic [31:0] thread_violation_count;
  logic [31:0] thread_nonroot_count;

  shadow_stack_return_checker_unit #(
    .THREADS(THREAD_COUNT),
    .STACK_DEPTH(STACK_LIMIT),
    .COUNT_BITS(32)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .thread(thread),
    .stack_word(stack_word),
    .read_ok(read_ok),
    .target_known(target_known),
    .ret_immediate(ret_immediate),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .expected_address(expected_address),
    .found_address(found_address),
    .repair(repair),
    .depth(depth),
    .violations_total(violations_total),
    .nonroot_total(nonroot_total),
    .thread_violation_count(thread_violation_count),
    .thread_nonroot_count(thread_nonroot_count)
  );

  always #2 clk = ~clk;

  // Configuration as last written.
  logic       filter_on = 1'b0;
  logic [2:0] watched = '0;
  logic       fixup_on = 1'b0;

  // Shadow stacks and counters as the block should hold them.
  logic [63:0] saved_returns [THREAD_COUNT][STACK_LIMIT];
  int          shadow_depth [THREAD_COUNT];
  logic [31:0] viol_all = '0;
  logic [31:0] nonroot_all = '0;
  logic [31:0] viol_by_thread [THREAD_COUNT];
  logic [31:0] nonroot_by_thread [THREAD_COUNT];

  // Stacks as the stimulus generator expects them after its queued events.
  logic [63:0] plan_words [THREAD_COUNT][STACK_LIMIT];
  int          plan_depth [THREAD_COUNT];

  event_t   event_queue [$];
  outcome_t expected_outcomes [$];
  event_t   offered;
  int       accepted_count = 0;
  int       hold_cycles = 0;
  logic     hold_done = 1'b0;
  logic     calm = 1'b0;
  int       mismatch_count = 0;

  initial begin
    for (int t = 0; t < THREAD_COUNT; t++) begin
      shadow_depth[t] = 0;
      plan_depth[t] = 0;
      viol_by_thread[t] = '0;
      nonroot_by_thread[t] = '0;
    end
  end

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic outcome_t predict_outcome(input event_t ev);
    outcome_t r;
    int t;
    int d;
    r = '0;
    r.status = ssrc_pkg::STATUS_FILTERED;
    t = ev.thread;
    d = shadow_depth[t];
    if (!(filter_on && ev.thread != watched)) begin
      if (ev.kind == ssrc_pkg::KIND_CALL) begin
        if (!ev.read_ok) begin
          r.status = ssrc_pkg::STATUS_READ_ERR;
        end else if (!ev.target_known) begin
          r.status = ssrc_pkg::STATUS_UNKNOWN;
        end else if (d >= STACK_LIMIT) begin
          r.status = ssrc_pkg::STATUS_FULL;
        end else begin
          saved_returns[t][d] = ev.word;
          shadow_depth[t] = d + 1;
          r.status = ssrc_pkg::STATUS_PUSHED;
        end
      end else if (d == 0) begin
        nonroot_all = sat_inc(nonroot_all);
        nonroot_by_thread[t] = sat_inc(nonroot_by_thread[t]);
        r.status = ssrc_pkg::STATUS_EMPTY;
      end else begin
        r.expected_address = saved_returns[t][d-1];
        if (!ev.read_ok) begin
          shadow_depth[t] = d - 1;
          r.status = ssrc_pkg::STATUS_READ_ERR;
        end else begin
          r.found_address = ev.word;
          if (ev.word == r.expected_address) begin
            shadow_depth[t] = d - 1;
            r.status = ssrc_pkg::STATUS_MATCH;
          end else if (ev.ret_immediate) begin
            r.status = ssrc_pkg::STATUS_FOLLOW;
          end else begin
            viol_all = sat_inc(viol_all);
            viol_by_thread[t] = sat_inc(viol_by_thread[t]);
            r.repair = fixup_on;
            shadow_depth[t] = d - 1;
            r.status = ssrc_pkg::STATUS_VIOLATION;
          end
        end
      end
    end
    r.depth = 7'(shadow_depth[t]);
    r.violations_total = viol_all;
    r.nonroot_total = nonroot_all;
    r.thread_violation_count = viol_by_thread[t];
    r.thread_nonroot_count = nonroot_by_thread[t];
    return r;
  endfunction

  // Queue an event and follow its effect on the planned stacks, so that later
  // returns can be given the address that is really on top.
  function automatic void queue_event(input event_t ev);
    int t;
    t = ev.thread;
    event_queue.push_back(ev);
    if (filter_on && ev.thread != watched) return;
    if (ev.kind == ssrc_pkg::KIND_CALL) begin
      if (ev.read_ok && ev.target_known && plan_depth[t] < STACK_LIMIT) begin
        plan_words[t][plan_depth[t]] = ev.word;
        plan_depth[t]++;
      end
    end else if (plan_depth[t] != 0) begin
      if (!ev.read_ok || ev.word == plan_words[t][plan_depth[t]-1] || !ev.ret_immediate)
        plan_depth[t]--;
    end
  endfunction

  function automatic void directed_event(input logic k, input logic [2:0] t,
                                         input logic [63:0] w, input logic ok,
                                         input logic known, input logic imm);
    event_t ev;
    ev.kind = k;
    ev.thread = t;
    ev.word = w;
    ev.read_ok = ok;
    ev.target_known = known;
    ev.ret_immediate = imm;
    queue_event(ev);
  endfunction

  task automatic random_events(input int count, input int call_pct);
    event_t ev;
    int t;
    for (int i = 0; i < count; i++) begin
      if (filter_on && $urandom_range(99) < 85) ev.thread = watched;
      else ev.thread = 3'($urandom_range(THREAD_COUNT - 1));
      ev.kind = ($urandom_range(99) < call_pct) ? ssrc_pkg::KIND_CALL : ssrc_pkg::KIND_RETURN;
      ev.word = {$urandom, $urandom};
      ev.read_ok = ($urandom_range(99) < 92);
      ev.target_known = ($urandom_range(99) < 90);
      ev.ret_immediate = ($urandom_range(99) < 25);
      t = ev.thread;
      if (ev.kind == ssrc_pkg::KIND_RETURN && plan_depth[t] != 0 && $urandom_range(99) < 70)
        ev.word = plan_words[t][plan_depth[t]-1];
      else if ($urandom_range(99) < 4)
        ev.word = $urandom_range(1) ? '1 : '0;
      queue_event(ev);
    end
  endtask

  // Checked between edges, so that a beat offered at the last edge is seen.
  task automatic wait_idle();
    while (event_queue.size() != 0 || in_valid || expected_outcomes.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_register(input logic [ssrc_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [ssrc_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ssrc_pkg::REG_FILTER_ENABLE:  filter_on = value[0];
      ssrc_pkg::REG_WATCHED_THREAD: watched = value[2:0];
      ssrc_pkg::REG_FIXUP_ENABLE:   fixup_on = value[0];
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("mismatch on %s: expected %h, got %h", field, want, got);
  endtask

  // Driver: holds a stalled beat, otherwise offers the next queued event or idles.
  always @(posedge clk) begin : drive_events
    event_t next_ev;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_outcomes.push_back(predict_outcome(offered));
        accepted_count <= accepted_count + 1;
      end
      if (!in_valid || !in_stall) begin
        if (event_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          next_ev = event_queue.pop_front();
          offered <= next_ev;
          kind <= next_ev.kind;
          thread <= next_ev.thread;
          stack_word <= next_ev.word;
          read_ok <= next_ev.read_ok;
          target_known <= next_ev.target_known;
          ret_immediate <= next_ev.ret_immediate;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off partway through, to back the block up.
  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (!hold_done && accepted_count == 400) begin
      hold_cycles <= 150;
      hold_done <= 1'b1;
    end
  end

  // Monitor: compares each accepted result beat with the oldest prediction.
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_outcomes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("result beat with no event pending: status %0d", status);
        end else begin
          want = expected_outcomes.pop_front();
          if (status != want.status)
            note_mismatch("status", 64'(want.status), 64'(status));
          if (expected_address != want.expected_address)
            note_mismatch("expected_address", want.expected_address, expected_address);
          if (found_address != want.found_address)
            note_mismatch("found_address", want.found_address, found_address);
          if (repair != want.repair)
            note_mismatch("repair", 64'(want.repair), 64'(repair));
          if (depth != want.depth)
            note_mismatch("depth", 64'(want.depth), 64'(depth));
          if (violations_total != want.violations_total)
            note_mismatch("violations_total", 64'(want.violations_total),
                          64'(violations_total));
          if (nonroot_total != want.nonroot_total)
            note_mismatch("nonroot_total", 64'(want.nonroot_total), 64'(nonroot_total));
          if (thread_violation_count != want.thread_violation_count)
            note_mismatch("thread_violation_count", 64'(want.thread_violation_count),
                          64'(thread_violation_count));
          if (thread_nonroot_count != want.thread_nonroot_count)
            note_mismatch("thread_nonroot_count", 64'(want.thread_nonroot_count),
                          64'(thread_nonroot_count));
        end
      end
      out_stall <= (hold_cycles != 0) || (!calm && $urandom_range(99) < IDLE_PCT);
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: no filtering, no repair requests.
    directed_event(ssrc_pkg::KIND_RETURN, 3'd0, 64'd0, 1'b0, 1'b1, 1'b0);
    directed_event(ssrc_pkg::KIND_CALL, 3'd1, 64'h0000_0000_0040_1000, 1'b0, 1'b1, 1'b0);
    directed_event(ssrc_pkg::KIND_CALL, 3'd1, 64'h0000_0000_0040_1010, 1'b1, 1'b0, 1'b0);
    directed_event(ssrc_pkg::KIND_CALL, 3'd0, 64'd0, 1'b1, 1'b1, 1'b0);
    directed_event(ssrc_pkg::KIND_CALL, 3'd0, '1, 1'b1, 1'b1, 1'b0);
    directed_event(ssrc_pkg::KIND_CALL, 3'd7, 64'h8000_0000_0000_0001, 1'b1, 1'b1, 1'b0);
    directed_event(ssrc_pkg::KIND_CALL, 3'd7, 64'h7FFF_FFFF_FFFF_FFFE, 1'b1, 1'b1, 1'b0);
    directed_event(ssrc_pkg::KIND_RETURN, 3'd0, '1, 1'b1, 1'b0, 1'b0);
    directed_event(ssrc_pkg::KIND_RETURN, 3'd0, 64'h0000_0000_0000_1234, 1'b1, 1'b0, 1'b1);
    directed_event(ssrc_pkg::KIND_RETURN, 3'd0, 64'h5555_5555_5555_5555, 1'b1, 1'b0, 1'b0);
    directed_event(ssrc_pkg::KIND_RETURN, 3'd0, '1, 1'b1, 1'b1, 1'b1);
    directed_event(ssrc_pkg::KIND_RETURN, 3'd7, 64'd0, 1'b0, 1'b0, 1'b0);
    directed_event(ssrc_pkg::KIND_RETURN, 3'd7, 64'h8000_0000_0000_0001, 1'b1, 1'b0, 1'b0);
    directed_event(ssrc_pkg::KIND_CALL, 3'd3, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b1);
    directed_event(ssrc_pkg::KIND_CALL, 3'd4, '1, 1'b1, 1'b1, 1'b1);
    directed_event(ssrc_pkg::KIND_RETURN, 3'd4, '1, 1'b1, 1'b1, 1'b1);
    wait_idle();

    write_register(ssrc_pkg::REG_FIXUP_ENABLE, 3'd1);
    write_register(ssrc_pkg::REG_FILTER_ENABLE, 3'd1);
    write_register(ssrc_pkg::REG_WATCHED_THREAD, 3'd7);
    directed_event(ssrc_pkg::KIND_CALL, 3'd7, 64'h0000_7FFF_0000_1000, 1'b1, 1'b1, 1'b0);
    directed_event(ssrc_pkg::KIND_RETURN, 3'd7, 64'h0000_7FFF_0000_2000, 1'b1, 1'b0, 1'b0);
    directed_event(ssrc_pkg::KIND_CALL, 3'd3, 64'h0000_0000_0000_00FF, 1'b1, 1'b1, 1'b0);
    directed_event(ssrc_pkg::KIND_RETURN, 3'd3, 64'h0000_0000_0000_00FF, 1'b1, 1'b0, 1'b0);
    random_events(250, 55);
    wait_idle();

    write_register(ssrc_pkg::REG_WATCHED_THREAD, 3'd0);
    write_register(ssrc_pkg::REG_FIXUP_ENABLE, 3'd0);
    random_events(250, 50);
    wait_idle();

    // Fill one stack past its limit, then run random events.
    write_register(ssrc_pkg::REG_FILTER_ENABLE, 3'd0);
    write_register(ssrc_pkg::REG_FIXUP_ENABLE, 3'd1);
    for (int i = 0; i < STACK_LIMIT + 4; i++)
      directed_event(ssrc_pkg::KIND_CALL, 3'd5, {$urandom, $urandom}, 1'b1, 1'b1, 1'b0);
    random_events(300, 65);
    wait_idle();

    // A stretch with no idling on either side.
    calm = 1'b1;
    write_register(ssrc_pkg::REG_FIXUP_ENABLE, 3'd0);
    random_events(350, 50);
    wait_idle();
    calm = 1'b0;

    write_register(ssrc_pkg::REG_FIXUP_ENABLE, 3'd1);
    write_register(ssrc_pkg::REG_WATCHED_THREAD, 3'd7);
    random_events(350, 45);
    wait_idle();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
